[rtl/core/rau_pkg.sv]
`default_nettype none
package rau_pkg;

  // Operation codes
  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_LT  = 3'd4;
  localparam logic [2:0] MODE_GT  = 3'd5;
  localparam logic [2:0] MODE_EQ  = 3'd6;
  localparam logic [2:0] MODE_NOP = 3'd7;

  // Datapath commands
  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_MUL1  = 3'd2,
    OP_MUL2  = 3'd3,
    OP_FORM  = 3'd4,
    OP_GCD   = 3'd5,
    OP_DIV   = 3'd6,
    OP_OUT   = 3'd7
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic early;     // result settled early (error, nop, compare)
    logic mag_zero;  // formed numerator magnitude is zero
    logic gcd_done;  // gcd loop finished
    logic div_done;  // quotient division finished
  } dp_sts_t;

endpackage
`default_nettype wire

[rtl/core/rau_ctrl.sv]
`default_nettype none
module rau_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  output logic                out_valid,
  output rau_pkg::dp_cmd_t    cmd,
  input  wire rau_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_FORM, S_CHK, S_GCD, S_DIV, S_OUT
  } state_t;

  state_t state_r;

  // Issue the command of the current state
  always_comb begin
    cmd.op = rau_pkg::OP_IDLE;
    case (state_r)
      S_IDLE: cmd.op = start ? rau_pkg::OP_LOAD : rau_pkg::OP_IDLE;
      S_MUL1: cmd.op = rau_pkg::OP_MUL1;
      S_MUL2: cmd.op = rau_pkg::OP_MUL2;
      S_FORM: cmd.op = rau_pkg::OP_FORM;
      S_CHK:  cmd.op = rau_pkg::OP_IDLE;
      S_GCD:  cmd.op = rau_pkg::OP_GCD;
      S_DIV:  cmd.op = rau_pkg::OP_DIV;
      S_OUT:  cmd.op = rau_pkg::OP_OUT;
      default: cmd.op = rau_pkg::OP_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // Sequence the transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: if (start) state_r <= S_MUL1;
        S_MUL1: state_r <= S_MUL2;
        // Error and unused-mode flags were registered at the end of MUL1
        S_MUL2: begin
          if (sts.early) begin
            state_r   <= S_IDLE;
            out_valid <= 1'b1;
          end else begin
            state_r <= S_FORM;
          end
        end
        S_FORM: state_r <= S_CHK;
        // Comparison outcome and zero numerator were registered at the end of FORM
        S_CHK: begin
          if (sts.early) begin
            state_r   <= S_IDLE;
            out_valid <= 1'b1;
          end else if (sts.mag_zero) begin
            state_r   <= S_IDLE;
            out_valid <= 1'b1;
          end else begin
            state_r <= S_GCD;
          end
        end
        S_GCD: if (sts.gcd_done) state_r <= S_DIV;
        S_DIV: if (sts.div_done) state_r <= S_OUT;
        S_OUT: begin
          state_r   <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/rau_dp.sv]
`default_nettype none
module rau_dp #(
  parameter int WIDTH = 32
) (
  input  wire                   clk,
  input  wire rau_pkg::dp_cmd_t cmd,
  output rau_pkg::dp_sts_t      sts,
  input  wire [2:0]             in_mode,
  input  wire signed [31:0]     in_a_num,
  input  wire [30:0]            in_a_den,
  input  wire signed [31:0]     in_b_num,
  input  wire [30:0]            in_b_den,
  output logic signed [31:0]    out_res_num,
  output logic [30:0]           out_res_den,
  output logic                  out_cmp_true,
  output logic                  out_div_by_zero,
  output logic                  out_overflow
);

  localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

  logic [2:0]         mode_r;
  logic signed [31:0] an_r, bn_r;
  logic [30:0]        ad_r, bd_r;
  logic signed [63:0] l_r, r_r, p_r, q_r;
  logic               neg_r;
  logic [63:0]        mag_r, den_r;
  logic [63:0]        gx_r, gy_r;
  logic [5:0]         sh_r;
  logic [5:0]         dcnt_r;
  logic               early_r;

  // Cross products a_num*b_den and b_num*a_den, one shared multiplier selected per step
  logic signed [31:0] ma;
  logic signed [32:0] mbx;
  logic signed [63:0] prod;
  always_comb begin
    ma  = an_r;
    mbx = {2'b00, bd_r};
    case (cmd.op)
      rau_pkg::OP_MUL1: begin ma = an_r;  mbx = {2'b00, bd_r}; end
      rau_pkg::OP_MUL2: begin ma = bn_r;  mbx = {2'b00, ad_r}; end
      default:          begin ma = an_r;  mbx = {2'b00, bd_r}; end
    endcase
    prod = 64'(ma * mbx);
  end

  // Binary gcd step helpers
  logic [63:0] gdiff;
  assign gdiff = (gx_r > gy_r) ? gx_r - gy_r : gy_r - gx_r;

  // Restoring division of mag and den by gcd: two quotients share one loop
  logic [63:0] g_val;
  assign g_val = gx_r << sh_r;

  logic [64:0] rm_n, rd_n;
  logic [63:0] qm_r, qd_r, remm_r, remd_r;
  always_comb begin
    rm_n = {remm_r, qm_r[63]};
    rd_n = {remd_r, qd_r[63]};
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rau_pkg::OP_LOAD: begin
        mode_r <= in_mode; an_r <= in_a_num; bn_r <= in_b_num;
        ad_r <= in_a_den; bd_r <= in_b_den;
      end
      rau_pkg::OP_MUL1: begin
        l_r <= prod;
        p_r <= 64'(an_r * bn_r);
        early_r <= 1'b1;
        out_res_num <= '0; out_res_den <= 31'd1;
        out_cmp_true <= 1'b0; out_div_by_zero <= 1'b0; out_overflow <= 1'b0;
        if (mode_r == rau_pkg::MODE_NOP) begin
          early_r <= 1'b1;
        end else if (ad_r == '0 || bd_r == '0) begin
          out_div_by_zero <= 1'b1;
        end else if (mode_r == rau_pkg::MODE_DIV && bn_r == '0) begin
          out_div_by_zero <= 1'b1;
        end else begin
          early_r <= 1'b0;
        end
      end
      rau_pkg::OP_MUL2: begin
        r_r <= prod;
        q_r <= 64'($signed({1'b0, ad_r}) * $signed(bn_r));
        den_r <= 64'({33'd0, ad_r} * {33'd0, bd_r});
      end
      rau_pkg::OP_FORM: begin
        logic signed [63:0] n;
        logic [63:0] d;
        n = 64'sd0;
        d = den_r;
        early_r <= 1'b0;
        case (mode_r)
          rau_pkg::MODE_ADD: n = l_r + r_r;
          rau_pkg::MODE_SUB: n = l_r - r_r;
          rau_pkg::MODE_MUL: n = p_r;
          rau_pkg::MODE_DIV: begin
            n = (q_r < 0) ? -l_r : l_r;
            d = (q_r < 0) ? 64'(-q_r) : 64'(q_r);
          end
          rau_pkg::MODE_LT: begin early_r <= 1'b1; out_cmp_true <= (l_r < r_r); end
          rau_pkg::MODE_GT: begin early_r <= 1'b1; out_cmp_true <= (l_r > r_r); end
          default:          begin early_r <= 1'b1; out_cmp_true <= (l_r == r_r); end
        endcase
        neg_r <= n[63];
        mag_r <= n[63] ? 64'(-n) : 64'(n);
        den_r <= d;
        gx_r  <= n[63] ? 64'(-n) : 64'(n);
        gy_r  <= d;
        sh_r  <= '0;
      end
      rau_pkg::OP_GCD: begin
        if (gx_r[0] == 1'b0 && gy_r[0] == 1'b0) begin
          gx_r <= gx_r >> 1; gy_r <= gy_r >> 1; sh_r <= sh_r + 6'd1;
        end else if (gx_r[0] == 1'b0) begin
          gx_r <= gx_r >> 1;
        end else if (gy_r[0] == 1'b0) begin
          gy_r <= gy_r >> 1;
        end else if (gx_r != gy_r) begin
          gx_r <= (gx_r < gy_r) ? gx_r : gy_r;
          gy_r <= gdiff;
        end
        qm_r <= mag_r; qd_r <= den_r; remm_r <= '0; remd_r <= '0;
        dcnt_r <= '0;
      end
      rau_pkg::OP_DIV: begin
        qm_r <= {qm_r[62:0], (rm_n >= {1'b0, g_val})};
        qd_r <= {qd_r[62:0], (rd_n >= {1'b0, g_val})};
        remm_r <= 64'((rm_n >= {1'b0, g_val}) ? rm_n - {1'b0, g_val} : rm_n);
        remd_r <= 64'((rd_n >= {1'b0, g_val}) ? rd_n - {1'b0, g_val} : rd_n);
        dcnt_r <= dcnt_r + 6'd1;
      end
      rau_pkg::OP_OUT: begin
        if (qd_r > LIM - 64'd1 || (neg_r ? qm_r > LIM : qm_r > LIM - 64'd1)) begin
          out_overflow <= 1'b1;
        end else begin
          out_res_num <= 32'(neg_r ? 64'(-qm_r) : qm_r);
          out_res_den <= 31'(qd_r);
        end
      end
      default: ;
    endcase
  end

  assign sts.early    = early_r;
  assign sts.mag_zero = (mag_r == '0);
  assign sts.gcd_done = (gx_r == gy_r);
  assign sts.div_done = (dcnt_r == 6'd63);

endmodule
`default_nettype wire

[rtl/core/rational_arithmetic_unit.sv]
`default_nettype none
// Rational arithmetic unit: start a transaction by raising start while busy is
// low; the result appears on the out_ ports for exactly one cycle with
// out_valid high, and the receiver cannot stall it. Errors and unused modes
// finish after the MUL2 check, comparisons and zero results after the CHK
// check, and reduced results after the binary gcd steps and a restoring
// division loop that the two quotients share. busy drops in the result cycle,
// so the next transaction can be accepted at the edge that ends it.
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire [2:0]         in_mode,
  input  wire signed [31:0] in_a_num,
  input  wire [30:0]        in_a_den,
  input  wire signed [31:0] in_b_num,
  input  wire [30:0]        in_b_den,
  output logic              out_valid,
  output logic signed [31:0] out_res_num,
  output logic [30:0]       out_res_den,
  output logic              out_cmp_true,
  output logic              out_div_by_zero,
  output logic              out_overflow
);

  rau_pkg::dp_cmd_t cmd;
  rau_pkg::dp_sts_t sts;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .cmd(cmd), .sts(sts)
  );

  rau_dp #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .cmd(cmd), .sts(sts),
    .in_mode(in_mode), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_cmp_true(out_cmp_true), .out_div_by_zero(out_div_by_zero),
    .out_overflow(out_overflow)
  );

endmodule
`default_nettype wire
